/* rtl/cbm_pkg.sv */
// Shared types, codes and address constants for the cartridge bank mapper.
// No dependencies; used by cbm_sound_ram, cbm_core and the top level.
`default_nettype none

package cbm_pkg;

  localparam int SOUND_RAM_DEPTH = 128;

  // bus action codes
  localparam logic [1:0] ACT_READ       = 2'd0;
  localparam logic [1:0] ACT_WRITE_LOW  = 2'd1;
  localparam logic [1:0] ACT_WRITE_HIGH = 2'd2;
  localparam logic [1:0] ACT_TICK       = 2'd3;

  // bank kinds
  localparam logic [1:0] KIND_CHR_ROM = 2'd0;
  localparam logic [1:0] KIND_CHR_RAM = 2'd1;
  localparam logic [1:0] KIND_NT_RAM  = 2'd2;
  localparam logic [1:0] KIND_PRG_ROM = 2'd3;

  // mirroring modes
  localparam logic [1:0] MIR_VERTICAL   = 2'd0;
  localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
  localparam logic [1:0] MIR_SINGLE_LOW = 2'd2;

  // variant register values
  localparam logic [1:0] VAR_NORMAL    = 2'd0;
  localparam logic [1:0] VAR_MIRROR_B6 = 2'd2;
  localparam logic [1:0] VAR_MIRROR_B7 = 2'd3;

  // address decode
  localparam logic [15:0] PAGE_MASK   = 16'hF800;
  localparam logic [15:0] ADDR_PORT   = 16'h4800;
  localparam logic [15:0] PAGE_CNT_LO = 16'h5000;
  localparam logic [15:0] PAGE_CNT_HI = 16'h5800;
  localparam logic [15:0] PAGE_PRG0   = 16'hE000;
  localparam logic [15:0] PAGE_PRG1   = 16'hE800;
  localparam logic [15:0] PAGE_PRG2   = 16'hF000;
  localparam logic [15:0] ADDR_PTR    = 16'hF800;

  localparam logic [14:0] CNT_MAX     = 15'h7FFF;
  localparam logic [7:0]  CHR_RAM_MIN = 8'hE0;
  localparam logic [7:0]  NT_MIN      = 8'hE0;

  localparam logic [3:0] SLOT_NT_BASE = 4'd8;
  localparam logic [3:0] SLOT_PRG0    = 4'd12;
  localparam logic [3:0] SLOT_PRG1    = 4'd13;
  localparam logic [3:0] SLOT_PRG2    = 4'd14;

  // one result transaction, last field in the low bits
  typedef struct packed {
    logic [1:0] mirror_mode;
    logic       mirror_valid;
    logic [7:0] bank_number;
    logic [1:0] bank_kind;
    logic [3:0] bank_slot;
    logic       bank_valid;
    logic       external_access;
    logic       irq_out;
    logic [7:0] read_data;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

/* rtl/cbm_sound_ram.sv */
// Sound RAM: synchronous single-port store; the read data is registered.
// Per-entry valid bits make unwritten entries read as zero after reset.
`default_nettype none

module cbm_sound_ram #(
  parameter int DEPTH = cbm_pkg::SOUND_RAM_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             re,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [7:0]       wdata,
  output logic      [7:0]       rdata
);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [7:0]       q;
  logic             q_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[idx] <= wdata;
    end
    if (re) begin
      q <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[idx] <= 1'b1;
      end
      if (re) begin
        q_vld <= vld[idx];
      end
    end
  end

  assign rdata = q_vld ? q : 8'd0;

endmodule

`default_nettype wire

/* rtl/cbm_core.sv */
// Decode and state update: RAM port pointer, IRQ counter, CHR RAM flags,
// variant register. Issues sound RAM requests. Depends on cbm_pkg.
`default_nettype none

module cbm_core #(
  parameter int DEPTH = cbm_pkg::SOUND_RAM_DEPTH,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [1:0]       action,
  input  wire logic [15:0]      address,
  input  wire logic [7:0]       write_data,
  input  wire logic [7:0]       tick_cycles,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_value,
  output logic                  ram_re,
  output logic                  ram_we,
  output logic      [IDX_W-1:0] ram_idx,
  output logic      [7:0]       ram_wdata,
  output logic                  ram_sel,
  output cbm_pkg::result_t      res
);

  logic [7:0]  ram_pointer, ram_pointer_next;
  logic        low_off, low_off_next;
  logic        high_off, high_off_next;
  logic [14:0] irq_count, irq_count_next;
  logic        irq_armed, irq_armed_next;
  logic        irq_line, irq_line_next;
  logic [1:0]  variant;

  logic [15:0] page;
  logic [15:0] tick_sum;
  logic [2:0]  chr_slot;
  logic        chr_off;
  logic        port_hit;

  assign page     = address & cbm_pkg::PAGE_MASK;
  assign tick_sum = {1'b0, irq_count} + {8'd0, tick_cycles};
  assign chr_slot = address[13:11];
  assign chr_off  = chr_slot[2] ? high_off : low_off;
  assign port_hit = (address == cbm_pkg::ADDR_PORT);
  assign ram_idx  = ram_pointer[IDX_W-1:0];
  assign ram_wdata = write_data;

  always_comb begin
    ram_pointer_next = ram_pointer;
    low_off_next     = low_off;
    high_off_next    = high_off;
    irq_count_next   = irq_count;
    irq_armed_next   = irq_armed;
    irq_line_next    = irq_line;
    ram_re           = 1'b0;
    ram_we           = 1'b0;
    ram_sel          = 1'b0;
    res              = '0;

    unique case (action)
      cbm_pkg::ACT_READ: begin
        if (page == cbm_pkg::ADDR_PORT) begin
          if (port_hit) begin
            ram_re  = 1'b1;
            ram_sel = 1'b1;
          end
        end else if (page == cbm_pkg::PAGE_CNT_LO) begin
          res.read_data = irq_count[7:0];
        end else if (page == cbm_pkg::PAGE_CNT_HI) begin
          res.read_data = {1'b0, irq_count[14:8]};
        end else if (address[15:13] == 3'b011) begin
          res.external_access = 1'b1;
        end else begin
          res.read_data = address[15:8];
        end
      end
      cbm_pkg::ACT_WRITE_LOW: begin
        if (page == cbm_pkg::ADDR_PORT) begin
          ram_we = port_hit;
        end else if (page == cbm_pkg::PAGE_CNT_LO) begin
          irq_count_next = {irq_count[14:8], write_data};
          irq_line_next  = 1'b0;
        end else if (page == cbm_pkg::PAGE_CNT_HI) begin
          irq_count_next = {write_data[6:0], irq_count[7:0]};
          irq_armed_next = write_data[7];
          irq_line_next  = 1'b0;
        end else if (address[15:13] == 3'b011) begin
          res.external_access = 1'b1;
        end
      end
      cbm_pkg::ACT_WRITE_HIGH: begin
        if (address[15:14] == 2'b10) begin
          res.bank_valid = 1'b1;
          res.bank_slot  = {1'b0, chr_slot};
          if (write_data < cbm_pkg::CHR_RAM_MIN || chr_off) begin
            res.bank_kind   = cbm_pkg::KIND_CHR_ROM;
            res.bank_number = write_data;
          end else begin
            res.bank_kind   = cbm_pkg::KIND_CHR_RAM;
            res.bank_number = {3'd0, write_data[4:0]};
          end
        end else if (address[15:13] == 3'b110) begin
          if (variant == cbm_pkg::VAR_NORMAL) begin
            res.bank_valid = 1'b1;
            res.bank_slot  = cbm_pkg::SLOT_NT_BASE | {2'd0, address[12:11]};
            if (write_data < cbm_pkg::NT_MIN) begin
              res.bank_kind   = cbm_pkg::KIND_CHR_ROM;
              res.bank_number = write_data;
            end else begin
              res.bank_kind   = cbm_pkg::KIND_NT_RAM;
              res.bank_number = {7'd0, write_data[0]};
            end
          end
        end else if (page == cbm_pkg::PAGE_PRG0) begin
          res.bank_valid  = 1'b1;
          res.bank_slot   = cbm_pkg::SLOT_PRG0;
          res.bank_kind   = cbm_pkg::KIND_PRG_ROM;
          res.bank_number = {2'd0, write_data[5:0]};
          if (variant == cbm_pkg::VAR_MIRROR_B6) begin
            res.mirror_valid = 1'b1;
            res.mirror_mode  = write_data[6] ? cbm_pkg::MIR_VERTICAL
                                             : cbm_pkg::MIR_SINGLE_LOW;
          end else if (variant == cbm_pkg::VAR_MIRROR_B7) begin
            res.mirror_valid = 1'b1;
            res.mirror_mode  = write_data[7] ? cbm_pkg::MIR_HORIZONTAL
                                             : cbm_pkg::MIR_VERTICAL;
          end
        end else if (page == cbm_pkg::PAGE_PRG1) begin
          low_off_next    = write_data[6];
          high_off_next   = write_data[7];
          res.bank_valid  = 1'b1;
          res.bank_slot   = cbm_pkg::SLOT_PRG1;
          res.bank_kind   = cbm_pkg::KIND_PRG_ROM;
          res.bank_number = {2'd0, write_data[5:0]};
        end else if (page == cbm_pkg::PAGE_PRG2) begin
          res.bank_valid  = 1'b1;
          res.bank_slot   = cbm_pkg::SLOT_PRG2;
          res.bank_kind   = cbm_pkg::KIND_PRG_ROM;
          res.bank_number = {2'd0, write_data[5:0]};
        end else if (address == cbm_pkg::ADDR_PTR) begin
          ram_pointer_next = write_data;
        end
      end
      cbm_pkg::ACT_TICK: begin
        if (irq_armed) begin
          if (tick_sum >= {1'b0, cbm_pkg::CNT_MAX}) begin
            irq_armed_next = 1'b0;
            irq_count_next = cbm_pkg::CNT_MAX;
            irq_line_next  = 1'b1;
          end else begin
            irq_count_next = tick_sum[14:0];
          end
        end
      end
      default: ;
    endcase

    // auto-increment keeps the top bit set
    if ((ram_re || ram_we) && ram_pointer[7]) begin
      ram_pointer_next = (ram_pointer + 8'd1) | 8'h80;
    end

    res.irq_out = irq_line_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_pointer <= '0;
      low_off     <= 1'b0;
      high_off    <= 1'b0;
      irq_count   <= '0;
      irq_armed   <= 1'b0;
      irq_line    <= 1'b0;
      variant     <= cbm_pkg::VAR_NORMAL;
    end else begin
      if (accept) begin
        ram_pointer <= ram_pointer_next;
        low_off     <= low_off_next;
        high_off    <= high_off_next;
        irq_count   <= irq_count_next;
        irq_armed   <= irq_armed_next;
        irq_line    <= irq_line_next;
      end
      if (cfg_we) begin
        variant <= cfg_value;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cartridge_bank_mapper_with_irq.sv */
// Top level of the cartridge bank mapper: stream ports, RAM stage and
// output register. Depends on cbm_pkg, cbm_core and cbm_sound_ram.
//
//  channel   | direction | transaction carries
//  s_axis    | in        | tuser: action[1:0]; tdata: address, write_data, tick_cycles
//  m_axis    | out       | tdata: one result per accepted item
//  cfg       | in        | data: variant[1:0]
//
// One item per cycle while the output is not stalled; each item passes the
// RAM stage (sound RAM read) and then the output register.
// State is updated in the cycle of acceptance; the RAM access is issued in
// the same cycle, so consecutive port accesses never overlap on one entry.
// Reset is synchronous; sound RAM reads zero after reset through per-entry
// valid bits, no clearing pass. An output stall holds the RAM stage and
// output register; s_axis_tready drops only when both are full.
`default_nettype none

module cartridge_bank_mapper_with_irq #(
  parameter int SOUND_RAM_DEPTH = cbm_pkg::SOUND_RAM_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] address, [23:16] write_data, [31:24] tick_cycles
  input  wire logic [31:0] s_axis_tdata,
  // [1:0] action
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] read_data, [8] irq_out, [9] external_access, [10] bank_valid,
  // [14:11] bank_slot, [16:15] bank_kind, [24:17] bank_number,
  // [25] mirror_valid, [27:26] mirror_mode, [31:28] zero
  output logic      [31:0] m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data
);

  localparam int IDX_W = $clog2(SOUND_RAM_DEPTH);

  logic             accept;
  logic             ram_re, ram_we, ram_sel;
  logic [IDX_W-1:0] ram_idx;
  logic [7:0]       ram_wdata, ram_rdata;
  cbm_pkg::result_t core_res;

  logic             s1_valid;
  logic             s1_ram_sel;
  cbm_pkg::result_t s1_res;
  cbm_pkg::result_t s1_merged;
  logic             s1_move;
  cbm_pkg::result_t out_res;

  assign cfg_ready     = 1'b1;
  assign s1_move       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cbm_core #(
    .DEPTH (SOUND_RAM_DEPTH),
    .IDX_W (IDX_W)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .action      (s_axis_tuser),
    .address     (s_axis_tdata[15:0]),
    .write_data  (s_axis_tdata[23:16]),
    .tick_cycles (s_axis_tdata[31:24]),
    .cfg_we      (cfg_valid),
    .cfg_value   (cfg_data),
    .ram_re      (ram_re),
    .ram_we      (ram_we),
    .ram_idx     (ram_idx),
    .ram_wdata   (ram_wdata),
    .ram_sel     (ram_sel),
    .res         (core_res)
  );

  // RAM requests only on acceptance, so the read data holds while stalled
  cbm_sound_ram #(
    .DEPTH (SOUND_RAM_DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .re    (ram_re && accept),
    .we    (ram_we && accept),
    .idx   (ram_idx),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      s1_valid      <= accept || (s1_valid && !s1_move);
      m_axis_tvalid <= s1_move || (m_axis_tvalid && !m_axis_tready);
    end
  end

  // port reads take their byte from the RAM output
  always_comb begin
    s1_merged = s1_res;
    if (s1_ram_sel) begin
      s1_merged.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res     <= core_res;
      s1_ram_sel <= ram_sel;
    end
    if (s1_move) begin
      out_res <= s1_merged;
    end
  end

  assign m_axis_tdata = {(32 - cbm_pkg::RESULT_W)'(0), out_res};

endmodule

`default_nettype wire

/* rtl/cbm_checker.sv */
// Port-level checks for the cartridge bank mapper, bound to the top level.
// Depends on the top-level port list only.
`default_nettype none

module cbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // bank fields are zero without a bank update
  a_bank_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[10] |-> m_axis_tdata[24:11] == 14'd0)
    else $error("bank fields set without bank_valid");

  // mirroring only rides on a program bank write in slot 12
  a_mirror: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[25] |->
      m_axis_tdata[10] && m_axis_tdata[14:11] == 4'd12 && m_axis_tdata[27:26] != 2'd3)
    else $error("bad mirroring report");

  // with the output free, input is never refused
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused while output empty");

endmodule

bind cartridge_bank_mapper_with_irq cbm_checker u_cbm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
